// ===== rtl/core/atsp_pkg.sv =====
// ----------------------------------------------------------------------------
// atsp_pkg
// Types, character codes and the value-size table shared by the auxiliary
// tag strand parser.
// ----------------------------------------------------------------------------
package atsp_pkg;

    typedef struct packed {
        logic [7:0] aux_byte;
        logic       last_byte;
    } t_aux_in;

    typedef struct packed {
        logic [1:0] strand;
        logic       parse_error;
    } t_aux_out;

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_FIXED  = 6'b000010,
        PH_STRING = 6'b000100,
        PH_COUNT  = 6'b001000,
        PH_ARRAY  = 6'b010000,
        PH_DRAIN  = 6'b100000
    } t_phase;

    typedef enum logic [2:0] {
        AK_UNKNOWN = 3'd0,
        AK_XB      = 3'd1,
        AK_XGZB    = 3'd2,
        AK_ZS      = 3'd3,
        AK_YD      = 3'd4
    } t_aligner;

    localparam logic [1:0] STRAND_NONE = 2'd0;
    localparam logic [1:0] STRAND_CT   = 2'd1;
    localparam logic [1:0] STRAND_GA   = 2'd2;

    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_LC_C  = 8'h63;
    localparam logic [7:0] CH_LC_D  = 8'h64;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_I  = 8'h69;
    localparam logic [7:0] CH_LC_R  = 8'h72;
    localparam logic [7:0] CH_LC_S  = 8'h73;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam int SKIP_W  = 7;
    localparam int COUNT_W = 32;

    // Value size per type code; string and array codes give their ASCII value
    function automatic logic [7:0] type_size(input logic [7:0] t);
        logic [7:0] s;
        unique case (t)
            CH_A, CH_C, CH_LC_C:    s = 8'd1;
            CH_S, CH_LC_S:          s = 8'd2;
            CH_I, CH_LC_I, CH_LC_F: s = 8'd4;
            CH_LC_D:                s = 8'd8;
            CH_Z:                   s = 8'd90;
            CH_H:                   s = 8'd72;
            CH_B:                   s = 8'd66;
            default:                s = 8'd0;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/core/atsp_in_stage.sv =====
// ----------------------------------------------------------------------------
// atsp_in_stage
// Input register: holds one item until the parse core consumes it.
// ----------------------------------------------------------------------------
module atsp_in_stage
    import atsp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_aux_in i_item,
    output logic    o_valid,
    output t_aux_in o_item,
    input  logic    i_take
);

    logic    r_valid;
    t_aux_in r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== rtl/core/atsp_parse_core.sv =====
// ----------------------------------------------------------------------------
// atsp_parse_core
// Field walker: tag, type and value bytes, strand match and error tracking.
// Gives the record result alongside the final byte and then clears itself.
// ----------------------------------------------------------------------------
module atsp_parse_core
    import atsp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  t_aux_in  i_item,
    output t_aux_out o_result
);

    t_phase              r_phase,    n_phase;
    logic [1:0]          r_hdr_cnt,  n_hdr_cnt;
    logic [7:0]          r_tag0,     n_tag0;
    t_aligner            r_kind,     n_kind;
    logic [7:0]          r_vtype,    n_vtype;
    logic [SKIP_W-1:0]   r_skip,     n_skip;
    logic [COUNT_W-1:0]  r_count,    n_count;
    logic [SKIP_W-1:0]   r_esize,    n_esize;
    logic [1:0]          r_strand,   n_strand;
    logic                r_err,      n_err;

    logic [7:0]          v;
    logic [7:0]          w_size_v;
    logic [7:0]          w_size_t;
    logic [SKIP_W-1:0]   w_skip_dec;
    logic [COUNT_W-1:0]  w_count_dec;
    logic                w_open;

    assign v           = i_item.aux_byte;
    assign w_size_v    = type_size(v);
    assign w_size_t    = type_size(r_vtype);
    assign w_skip_dec  = r_skip - SKIP_W'(1);
    assign w_count_dec = r_count - COUNT_W'(1);

    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_tag0    = r_tag0;
        n_kind    = r_kind;
        n_vtype   = r_vtype;
        n_skip    = r_skip;
        n_count   = r_count;
        n_esize   = r_esize;
        n_strand  = r_strand;
        n_err     = r_err;

        unique case (r_phase)
            PH_HEADER: begin
                unique case (r_hdr_cnt)
                    2'd0: begin
                        n_tag0    = v;
                        n_hdr_cnt = 2'd1;
                    end
                    2'd1: begin
                        n_kind = AK_UNKNOWN;
                        if (r_tag0 == CH_Z) begin
                            if (v == CH_B)      n_kind = AK_XGZB;
                            else if (v == CH_S) n_kind = AK_ZS;
                        end else if (r_tag0 == CH_X) begin
                            if (v == CH_G)      n_kind = AK_XGZB;
                            else if (v == CH_B) n_kind = AK_XB;
                        end else if (r_tag0 == CH_Y && v == CH_D) begin
                            n_kind = AK_YD;
                        end
                        n_hdr_cnt = 2'd2;
                    end
                    2'd2: begin
                        // unknown type: the next byte opens a new tag
                        n_vtype   = v;
                        n_hdr_cnt = (w_size_v == 8'd0) ? 2'd0 : 2'd3;
                    end
                    default: begin
                        n_hdr_cnt = 2'd0;
                        if (r_vtype == CH_A) begin
                            if (r_kind == AK_XB) begin
                                if (v == CH_C)      n_strand = STRAND_CT;
                                else if (v == CH_G) n_strand = STRAND_GA;
                            end
                        end else if (r_vtype == CH_Z || r_vtype == CH_H) begin
                            if (r_vtype == CH_Z) begin
                                if (r_kind == AK_XGZB) begin
                                    if (v == CH_C)          n_strand = STRAND_CT;
                                    else if (v == CH_G)     n_strand = STRAND_GA;
                                end else if (r_kind == AK_ZS) begin
                                    if (v == CH_PLUS)       n_strand = STRAND_CT;
                                    else if (v == CH_MINUS) n_strand = STRAND_GA;
                                end else if (r_kind == AK_YD) begin
                                    if (v == CH_LC_F)       n_strand = STRAND_CT;
                                    else if (v == CH_LC_R)  n_strand = STRAND_GA;
                                end
                            end
                            n_phase = (v == CH_NUL) ? PH_HEADER : PH_STRING;
                        end else if (r_vtype == CH_B) begin
                            n_esize = SKIP_W'(w_size_v);
                            if (w_size_v == 8'd0) begin
                                n_err   = 1'b1;
                                n_phase = PH_DRAIN;
                            end else begin
                                n_count = '0;
                                n_skip  = SKIP_W'(4);
                                n_phase = PH_COUNT;
                            end
                        end else begin
                            n_skip  = SKIP_W'(w_size_t - 8'd1);
                            n_phase = (w_size_t == 8'd1) ? PH_HEADER : PH_FIXED;
                        end
                    end
                endcase
            end
            PH_FIXED: begin
                n_skip = w_skip_dec;
                if (w_skip_dec == '0) n_phase = PH_HEADER;
            end
            PH_STRING: begin
                if (v == CH_NUL) n_phase = PH_HEADER;
            end
            PH_COUNT: begin
                // count arrives little-endian, four bytes down to one to go
                unique case (r_skip[2:0])
                    3'd4:    n_count[7:0]   = r_count[7:0]   | v;
                    3'd3:    n_count[15:8]  = r_count[15:8]  | v;
                    3'd2:    n_count[23:16] = r_count[23:16] | v;
                    default: n_count[31:24] = r_count[31:24] | v;
                endcase
                n_skip = w_skip_dec;
                if (w_skip_dec == '0) begin
                    if (n_count == '0) begin
                        n_phase = PH_HEADER;
                    end else begin
                        n_skip  = r_esize;
                        n_phase = PH_ARRAY;
                    end
                end
            end
            PH_ARRAY: begin
                n_skip = w_skip_dec;
                if (w_skip_dec == '0) begin
                    n_count = w_count_dec;
                    if (w_count_dec == '0) n_phase = PH_HEADER;
                    else                   n_skip  = r_esize;
                end
            end
            PH_DRAIN: begin
            end
            default: begin
            end
        endcase
    end

    assign w_open = (n_phase == PH_FIXED) || (n_phase == PH_STRING)
                 || (n_phase == PH_COUNT) || (n_phase == PH_ARRAY);

    assign o_result.strand      = n_strand;
    assign o_result.parse_error = n_err || w_open;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last_byte)) begin
            r_phase   <= PH_HEADER;
            r_hdr_cnt <= 2'd0;
            r_tag0    <= 8'd0;
            r_kind    <= AK_UNKNOWN;
            r_vtype   <= 8'd0;
            r_skip    <= '0;
            r_count   <= '0;
            r_esize   <= '0;
            r_strand  <= STRAND_NONE;
            r_err     <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_tag0    <= n_tag0;
            r_kind    <= n_kind;
            r_vtype   <= n_vtype;
            r_skip    <= n_skip;
            r_count   <= n_count;
            r_esize   <= n_esize;
            r_strand  <= n_strand;
            r_err     <= n_err;
        end
    end

endmodule

// ===== rtl/core/atsp_out_stage.sv =====
// ----------------------------------------------------------------------------
// atsp_out_stage
// Result register: holds the record result until the receiver takes it.
// ----------------------------------------------------------------------------
module atsp_out_stage
    import atsp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_aux_out i_result,
    output logic     o_free,
    output logic     o_valid,
    input  logic     i_ready,
    output t_aux_out o_result
);

    logic     r_valid;
    t_aux_out r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== rtl/core/aux_tag_strand_parser.sv =====
// ----------------------------------------------------------------------------
// aux_tag_strand_parser
// Bisulfite strand and layout check over the auxiliary fields of a record.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready / i_in_item): one byte of the
// auxiliary region per item, last_byte set on the final byte of a record.
// Output channel (o_out_valid / i_out_ready / o_out_result): one item per
// record, carrying the strand code and the parse error flag.
// Throughput is one byte per cycle while no final byte waits for the result
// register; records follow one another with no gap. A byte is held in the
// input register and is parsed as it leaves it. The result of a final byte
// is loaded into the result register as that byte leaves the input register.
// The rate is set by the field walker, combinational between the registers.
// A stalled receiver holds the result; bytes that are not final keep flowing,
// and a final byte waits in the input register, with o_in_ready low, until
// the result register frees.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// walker to the start of a record. No result is given for bytes not marked
// last.
// ----------------------------------------------------------------------------
module aux_tag_strand_parser
    import atsp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_aux_in  i_in_item,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_aux_out o_out_result
);

    logic     w_in_valid;
    t_aux_in  w_in_item;
    logic     w_out_free;
    logic     w_advance;
    logic     w_load;
    t_aux_out w_result;

    assign w_advance = w_in_valid && (!w_in_item.last_byte || w_out_free);
    assign w_load    = w_advance && w_in_item.last_byte;

    atsp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .o_valid (w_in_valid),
        .o_item  (w_in_item),
        .i_take  (w_advance)
    );

    atsp_parse_core u_parse_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_item   (w_in_item),
        .o_result (w_result)
    );

    atsp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (o_out_result)
    );

`ifndef SYNTHESIS
    a_strand_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_result.strand != 2'd3))
        else $error("strand code out of range");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_load))
        else $error("result appeared without a final byte");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_valid && !w_advance) |=> (w_in_valid && $stable(w_in_item)))
        else $error("pending byte lost from input register");
`endif

endmodule
